// File: hw/rtl/assert_macros.svh
// Assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked, reset-qualified property check
`define BPC_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// same check on the default clk and rst_n of the enclosing module
`define BPC_ASSERT_DEF(label, prop, msg) `BPC_ASSERT(label, clk, rst_n, prop, msg)

`endif

// File: hw/rtl/bpc_pkg.sv
// Types, constants and codes of the button press classifier
package bpc_pkg;

    localparam int TIME_W        = 32;
    localparam int PIN_W         = 4;
    localparam int PORT_PINS     = 16;
    localparam int PIN_COUNT_DEF = 16;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [31:0] EDGE_MODES_RST = 32'd0;
    localparam logic [15:0] LP_MASK_RST    = 16'd0;
    localparam logic [31:0] LP_MS_RST      = 32'd1000;
    localparam logic [15:0] HOLDOFF_RST    = 16'd60;

    typedef enum logic [1:0] {
        MODE_UNUSED = 2'd0,
        MODE_POS    = 2'd1,
        MODE_NEG    = 2'd2,
        MODE_ANY    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_ANY   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_EDGE_MODES = 2'd0,
        REG_LP_MASK    = 2'd1,
        REG_LP_MS      = 2'd2,
        REG_HOLDOFF    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] edge_modes;
        logic [15:0] long_press_mask;
        logic [31:0] long_press_ms;
        logic [15:0] holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [PIN_W-1:0]  addr;
        logic [TIME_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic rep_pending;
    } seq_stat_t;

endpackage

// File: hw/rtl/bpc_if.sv
// Snapshot and event channel interfaces
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] intr_flags;
    logic [15:0] captured_levels;
    logic [31:0] now_ms;

    modport source (output valid, intr_flags, captured_levels, now_ms, input ready);
    modport sink (input valid, intr_flags, captured_levels, now_ms, output ready);
endinterface

interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pin_number;
    logic [1:0] event_kind;
    logic       pin_level;
    logic       last_event;

    modport source (output valid, pin_number, event_kind, pin_level, last_event, input ready);
    modport sink (input valid, pin_number, event_kind, pin_level, last_event, output ready);
endinterface

// File: hw/rtl/bpc_regs.sv
// APB configuration registers
module bpc_regs
    import bpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_modes      <= EDGE_MODES_RST;
            cfg_reg.long_press_mask <= LP_MASK_RST;
            cfg_reg.long_press_ms   <= LP_MS_RST;
            cfg_reg.holdoff_ms      <= HOLDOFF_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_EDGE_MODES: cfg_reg.edge_modes      <= pwdata;
                REG_LP_MASK:    cfg_reg.long_press_mask <= pwdata[15:0];
                REG_LP_MS:      cfg_reg.long_press_ms   <= pwdata;
                REG_HOLDOFF:    cfg_reg.holdoff_ms      <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_EDGE_MODES: prdata = cfg_reg.edge_modes;
            REG_LP_MASK:    prdata = {16'd0, cfg_reg.long_press_mask};
            REG_LP_MS:      prdata = cfg_reg.long_press_ms;
            REG_HOLDOFF:    prdata = {16'd0, cfg_reg.holdoff_ms};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/bpc_time_mem.sv
// Press time memory, one entry per pin, registered read
module bpc_time_mem
    import bpc_pkg::*;
#(
    parameter int NPINS = PIN_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [TIME_W-1:0] rdata
);

    localparam int IDX_W = (NPINS > 1) ? $clog2(NPINS) : 1;

    logic [TIME_W-1:0] time_mem_reg [NPINS];
    logic [NPINS-1:0]  valid_reg;
    logic [TIME_W-1:0] rdata_reg;
    logic [IDX_W-1:0]  idx;

    assign idx   = req.addr[IDX_W-1:0];
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            time_mem_reg[idx] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= valid_reg[idx] ? time_mem_reg[idx] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

endmodule

// File: hw/rtl/bpc_seq.sv
// Snapshot sequencer: holdoff, pin scan and event classification
module bpc_seq
    import bpc_pkg::*;
#(
    parameter int NPINS = PIN_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    bpc_in_if.sink            in_ch,
    bpc_out_if.source         out_ch,
    output mem_req_t          mem_req,
    input  logic [TIME_W-1:0] mem_rdata,
    output seq_stat_t         stat
);

    localparam int IDX_W = (NPINS > 1) ? $clog2(NPINS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [NPINS-1:0]  press_rem_reg, press_rem_next;
    logic [NPINS-1:0]  rep_rem_reg, rep_rem_next;
    logic [NPINS-1:0]  levels_reg, levels_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] last_acc_reg, last_acc_next;
    logic [IDX_W-1:0]  pin_reg, pin_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]  out_pin_reg, out_pin_next;
    kind_t             out_kind_reg, out_kind_next;
    logic              out_level_reg, out_level_next;
    logic              out_last_reg, out_last_next;

    logic [NPINS-1:0]  press_mask, rep_mask, work, sel_bit;
    logic [IDX_W-1:0]  sel;
    mode_t             sel_mode;
    logic [TIME_W-1:0] gap, held;
    logic              slot_free, accept;

    always_comb
    begin
        mode_t m;
        logic  f;
        logic  l;
        for (int p = 0; p < NPINS; p++)
        begin
            m = mode_t'(cfg.edge_modes[2*p +: 2]);
            f = in_ch.intr_flags[p];
            l = in_ch.captured_levels[p];
            press_mask[p] = f && ((m == MODE_POS && !l) || (m == MODE_NEG && l));
            rep_mask[p]   = f && ((m == MODE_POS && l) || (m == MODE_NEG && !l)
                                  || m == MODE_ANY);
        end
    end

    always_comb
    begin
        sel = '0;
        for (int i = NPINS - 1; i >= 0; i--)
        begin
            if (work[i])
            begin
                sel = IDX_W'(i);
            end
        end
    end

    assign work      = press_rem_reg | rep_rem_reg;
    assign sel_bit   = NPINS'(1) << sel;
    assign sel_mode  = mode_t'(cfg.edge_modes[{sel, 1'b0} +: 2]);
    assign gap       = in_ch.now_ms - last_acc_reg;
    assign held      = now_reg - mem_rdata;
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign accept    = in_ch.valid && in_ch.ready;

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pin_number = out_pin_reg;
    assign out_ch.event_kind = out_kind_reg;
    assign out_ch.pin_level  = out_level_reg;
    assign out_ch.last_event = out_last_reg;
    assign stat.rep_pending  = |rep_rem_reg;

    always_comb
    begin
        state_next     = state_reg;
        press_rem_next = press_rem_reg;
        rep_rem_next   = rep_rem_reg;
        levels_next    = levels_reg;
        now_next       = now_reg;
        last_acc_next  = last_acc_reg;
        pin_next       = pin_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_pin_next   = out_pin_reg;
        out_kind_next  = out_kind_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        mem_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && gap >= {16'd0, cfg.holdoff_ms})
                begin
                    last_acc_next  = in_ch.now_ms;
                    now_next       = in_ch.now_ms;
                    levels_next    = in_ch.captured_levels[NPINS-1:0];
                    press_rem_next = press_mask;
                    rep_rem_next   = rep_mask;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (work == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (press_rem_reg[sel])
                begin
                    mem_req.we     = 1'b1;
                    mem_req.addr   = PIN_W'(sel);
                    mem_req.wdata  = now_reg;
                    press_rem_next = press_rem_reg & ~sel_bit;
                end
                else if (sel_mode == MODE_ANY)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_pin_next   = PIN_W'(sel);
                        out_kind_next  = KIND_ANY;
                        out_level_next = levels_reg[sel];
                        out_last_next  = (rep_rem_reg & ~sel_bit) == '0;
                        rep_rem_next   = rep_rem_reg & ~sel_bit;
                    end
                end
                else
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = PIN_W'(sel);
                    pin_next     = sel;
                    state_next   = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_pin_next   = PIN_W'(pin_reg);
                    out_kind_next  = (held <= cfg.long_press_ms
                                      || !cfg.long_press_mask[pin_reg])
                                     ? KIND_SHORT : KIND_LONG;
                    out_level_next = levels_reg[pin_reg];
                    out_last_next  = (rep_rem_reg & ~(NPINS'(1) << pin_reg)) == '0;
                    rep_rem_next   = rep_rem_reg & ~(NPINS'(1) << pin_reg);
                    state_next     = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            press_rem_reg <= '0;
            rep_rem_reg   <= '0;
            last_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            press_rem_reg <= press_rem_next;
            rep_rem_reg   <= rep_rem_next;
            last_acc_reg  <= last_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        levels_reg    <= levels_next;
        now_reg       <= now_next;
        pin_reg       <= pin_next;
        out_pin_reg   <= out_pin_next;
        out_kind_reg  <= out_kind_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// File: hw/rtl/button_press_classifier_core.sv
// Top level of the button press classifier
//
//   channel  direction  handshake              payload
//   in_ch    sink       valid/ready            intr_flags, captured_levels, now_ms
//   out_ch   source     valid/ready            pin_number, event_kind, pin_level, last_event
//   apb      slave      psel/penable, pready=1 paddr, pwdata, prdata
//
// A snapshot is accepted in S_IDLE; S_SCAN then handles each flagged press pin (write of the
// press time) or any-edge pin, and each release pin via a memory read and S_WAIT, then returns idle.
// One snapshot is in work at a time; in_ch.ready is high only when the scan is done.
// A full output register stalls the scan; the pending event waits there.
// rst_n clears the control state and the memory's valid bits at once.
`include "assert_macros.svh"

module button_press_classifier_core
    import bpc_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bpc_in_if.sink                in_ch,
    bpc_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NPINS = (PIN_COUNT < PORT_PINS) ? PIN_COUNT : PORT_PINS;

    cfg_t              cfg;
    mem_req_t          mem_req;
    logic [TIME_W-1:0] mem_rdata;
    seq_stat_t         stat;

    bpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpc_time_mem #(.NPINS(NPINS)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    bpc_seq #(.NPINS(NPINS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .stat      (stat)
    );

    `BPC_ASSERT_DEF(a_idle_no_reports, in_ch.ready |-> !stat.rep_pending, "ready with events left")
    `BPC_ASSERT_DEF(a_kind_valid, out_ch.valid |-> out_ch.event_kind != 2'd3, "bad event kind")
    `BPC_ASSERT_DEF(a_long_masked, out_ch.valid && out_ch.event_kind == KIND_LONG |-> cfg.long_press_mask[out_ch.pin_number], "long press on unmasked pin")

endmodule
